>>> hw/rtl/sspq_pkg.sv
// shared types, constants and codes for the stable sorted priority queue
package sspq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int COUNT_W     = 5;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W       = (OCC_W > COUNT_W) ? OCC_W : COUNT_W;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    logic signed [31:0] item;
    logic signed [15:0] prio;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   new_entry;
  } cell_ctrl_t;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] item;
    logic signed [15:0] priority_req;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_item;
    logic signed [15:0] removed_priority;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic signed [31:0] head_item;
    logic signed [15:0] head_priority;
  } out_res_t;

endpackage

>>> hw/rtl/sspq_cell.sv
// one slot of the sorted chain: keeps, takes the new entry, or shifts
module sspq_cell (
  input  logic                clk,
  input  sspq_pkg::cell_ctrl_t ctrl,
  input  logic                occ,
  input  sspq_pkg::entry_t    left_ent,
  input  logic                left_keep,
  input  sspq_pkg::entry_t    right_ent,
  output sspq_pkg::entry_t    ent,
  output logic                keep
);

  sspq_pkg::entry_t ent_r;
  sspq_pkg::entry_t ent_nxt;

  assign ent  = ent_r;
  assign keep = occ && (ent_r.prio <= ctrl.new_entry.prio);

  always_comb begin
    unique case (ctrl.op)
      sspq_pkg::CELL_HOLD: begin
        ent_nxt = ent_r;
      end
      sspq_pkg::CELL_INSERT: begin
        if (keep) begin
          ent_nxt = ent_r;
        end else if (left_keep) begin
          ent_nxt = ctrl.new_entry;
        end else begin
          ent_nxt = left_ent;
        end
      end
      sspq_pkg::CELL_REMOVE: begin
        ent_nxt = right_ent;
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

>>> hw/rtl/stable_sorted_priority_queue.sv
// top level: sorted chain of slots, entry count and result register
//
// channel   direction  handshake               payload
// in_       input      start high, busy low    in_req   (sspq_pkg::in_req_t)
// out_      output     out_valid, one cycle    out_res  (sspq_pkg::out_res_t)
//
// one request per cycle: every slot compares against the new priority at once
// and loads, keeps or shifts in the same cycle, so busy stays low
// the result is registered and appears in the cycle after the request is taken
// synchronous active-low reset clears the entry count and the result strobe
// results cannot be stalled; each is shown for exactly one cycle
module stable_sorted_priority_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sspq_pkg::in_req_t  in_req,
  output logic               out_valid,
  output sspq_pkg::out_res_t out_res
);

  localparam int D = sspq_pkg::QUEUE_DEPTH;
  localparam int W = sspq_pkg::CNT_W;

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [W-1:0]         count_r;
  logic [W-1:0]         count_nxt;
  logic                 out_valid_r;
  sspq_pkg::status_t    status_r;
  sspq_pkg::status_t    status_nxt;
  sspq_pkg::entry_t     removed_r;
  sspq_pkg::entry_t     removed_nxt;
  sspq_pkg::cell_ctrl_t ctrl;
  sspq_pkg::entry_t     ent  [D];
  logic [D-1:0]         keep;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == W'(D));
  assign empty  = (count_r == '0);

  always_comb begin
    ctrl.new_entry.item = in_req.item;
    ctrl.new_entry.prio = in_req.priority_req;
    ctrl.op             = sspq_pkg::CELL_HOLD;
    count_nxt           = count_r;
    status_nxt          = sspq_pkg::STATUS_OK;
    removed_nxt         = '0;
    if (accept) begin
      if (in_req.req_type == sspq_pkg::REQ_INSERT) begin
        if (full) begin
          status_nxt = sspq_pkg::STATUS_FULL;
        end else begin
          ctrl.op   = sspq_pkg::CELL_INSERT;
          count_nxt = count_r + W'(1);
        end
      end else begin
        if (empty) begin
          status_nxt = sspq_pkg::STATUS_EMPTY;
        end else begin
          ctrl.op     = sspq_pkg::CELL_REMOVE;
          count_nxt   = count_r - W'(1);
          removed_nxt = ent[0];
        end
      end
    end
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    sspq_pkg::entry_t left_ent;
    sspq_pkg::entry_t right_ent;
    logic             left_keep;
    if (i == 0) begin : g_first
      assign left_ent  = ctrl.new_entry;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left_ent  = ent[i-1];
      assign left_keep = keep[i-1];
    end
    if (i == D - 1) begin : g_last
      assign right_ent = ent[i];
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end
    sspq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (count_r > W'(i)),
      .left_ent  (left_ent),
      .left_keep (left_keep),
      .right_ent (right_ent),
      .ent       (ent[i]),
      .keep      (keep[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
  end

  assign out_valid                = out_valid_r;
  assign out_res.status           = status_r;
  assign out_res.removed_item     = removed_r.item;
  assign out_res.removed_priority = removed_r.prio;
  assign out_res.count            = count_r[sspq_pkg::COUNT_W-1:0];
  assign out_res.is_empty         = empty;
  assign out_res.head_item        = empty ? '0 : ent[0].item;
  assign out_res.head_priority    = empty ? '0 : ent[0].prio;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= W'(D))
    else $error("entry count above depth");

  a_strobe_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("request without result strobe");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status_r == sspq_pkg::STATUS_FULL) |-> full)
    else $error("full rejection while not full");

  a_empty_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status_r == sspq_pkg::STATUS_EMPTY) |-> empty && (removed_r == '0))
    else $error("empty remove changed state or reported an entry");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(accept) |-> $stable(count_r))
    else $error("count changed without a request");

endmodule
